// File: design/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types and codes of the JSON string unescape decoder: decoder phases,
// result kinds, error codes and the result group passed to the output stage.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Decoder phases. The body phase is the reset phase.
    typedef enum logic [2:0] {
        PH_BODY      = 3'd0,
        PH_ESC       = 3'd1,
        PH_UTF8      = 3'd2,
        PH_HEX_FIRST = 3'd3,
        PH_PAIR_BSL  = 3'd4,
        PH_PAIR_U    = 3'd5,
        PH_HEX_LOW   = 3'd6
    } phase_t;

    // Kind of one result transaction.
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Error codes carried with an error result.
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd1;
    localparam logic [3:0] ERR_CONTROL      = 4'd2;
    localparam logic [3:0] ERR_BAD_UTF8     = 4'd3;
    localparam logic [3:0] ERR_ESC_END      = 4'd4;
    localparam logic [3:0] ERR_BAD_ESC      = 4'd5;
    localparam logic [3:0] ERR_HEX_TRUNC    = 4'd6;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd7;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd8;
    localparam logic [3:0] ERR_LONE_HIGH    = 4'd9;

    // Most results one input byte can cause.
    localparam int unsigned MAX_RESULTS = 4;

    // All results caused by one input byte. A close or an error is always
    // the only result of its byte; decoded bytes fill bytes[0] upwards.
    typedef struct packed {
        logic [2:0]                   count;
        kind_t                        kind;
        logic [3:0]                   err;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } batch_t;

endpackage
`default_nettype wire

// File: design/jsu_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape step
// Holds the decoder state and, in one pass of combinational logic, turns one
// registered input byte into the group of results that it causes.
// ----------------------------------------------------------------------------
module jsu_step
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_valid,
    input  wire logic [7:0] step_byte,
    input  wire logic       step_eot,
    output batch_t          batch
);

    typedef struct packed {
        logic [2:0]       count;
        logic [3:0][7:0]  bytes;
    } cp_bytes_t;

    // UTF-8 encoding of one code point, one to four bytes.
    function automatic cp_bytes_t encode_cp(input logic [20:0] cp);
        cp_bytes_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.count    = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.count    = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.count    = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // Decoder state.
    phase_t          phase_reg, phase_next;
    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      remaining_reg, remaining_next;
    logic [2:0]      length_reg, length_next;
    logic [20:0]     cp_reg, cp_next;
    logic [15:0]     hex_reg, hex_next;
    logic [2:0]      hex_cnt_reg, hex_cnt_next;
    logic            hex_bad_reg, hex_bad_next;
    logic [9:0]      high_reg, high_next;

    // Shared decode terms.
    logic            is_cont;
    logic [20:0]     cp_cont;
    logic [1:0]      remaining_dec;
    logic [2:0]      held_pos;
    logic [20:0]     cp_minimum;
    logic            utf8_bad_final;
    logic [2:0]      lead_len;
    logic [20:0]     lead_cp;
    logic [3:0]      digit;
    logic            digit_bad;
    logic [15:0]     hex_new;
    logic [2:0]      hex_cnt_new;
    logic            hex_done;
    logic            hex_bad_any;
    logic            hex_is_low;
    logic            hex_is_high;
    logic [20:0]     pair_cp;
    cp_bytes_t       enc;

    // Terms used by both the next-state and the output logic.
    always_comb begin
        is_cont       = (step_byte[7:6] == 2'b10);
        cp_cont       = {cp_reg[14:0], step_byte[5:0]};
        remaining_dec = remaining_reg - 2'd1;
        held_pos      = length_reg - {1'b0, remaining_reg};

        case (length_reg)
            3'd2:    cp_minimum = 21'h80;
            3'd3:    cp_minimum = 21'h800;
            default: cp_minimum = 21'h10000;
        endcase
        utf8_bad_final = (cp_cont < cp_minimum) || (cp_cont > 21'h10FFFF) ||
                         ((cp_cont >= 21'hD800) && (cp_cont <= 21'hDFFF));

        // Lead byte of a raw multi-byte sequence; zero length means a bad lead.
        if (step_byte >= 8'hC2 && step_byte <= 8'hDF) begin
            lead_len = 3'd2;
            lead_cp  = {16'd0, step_byte[4:0]};
        end else if (step_byte >= 8'hE0 && step_byte <= 8'hEF) begin
            lead_len = 3'd3;
            lead_cp  = {17'd0, step_byte[3:0]};
        end else if (step_byte >= 8'hF0 && step_byte <= 8'hF4) begin
            lead_len = 3'd4;
            lead_cp  = {18'd0, step_byte[2:0]};
        end else begin
            lead_len = 3'd0;
            lead_cp  = '0;
        end

        // Hex digit; a bad digit counts as zero and is remembered.
        digit_bad = 1'b0;
        if (step_byte >= 8'h30 && step_byte <= 8'h39) begin
            digit = step_byte[3:0];
        end else if ((step_byte >= 8'h61 && step_byte <= 8'h66) ||
                     (step_byte >= 8'h41 && step_byte <= 8'h46)) begin
            digit = step_byte[3:0] + 4'd9;
        end else begin
            digit     = 4'd0;
            digit_bad = 1'b1;
        end
        hex_new     = {hex_reg[11:0], digit};
        hex_cnt_new = hex_cnt_reg + 3'd1;
        hex_done    = (hex_cnt_new >= 3'd4);
        hex_bad_any = hex_bad_reg | digit_bad;
        hex_is_low  = (hex_new >= 16'hDC00) && (hex_new <= 16'hDFFF);
        hex_is_high = (hex_new >= 16'hD800) && (hex_new <= 16'hDBFF);

        pair_cp = 21'h10000 + {1'b0, high_reg, hex_new[9:0]};
        if (phase_reg == PH_HEX_LOW) begin
            enc = encode_cp(pair_cp);
        end else begin
            enc = encode_cp({5'd0, hex_new});
        end
    end

    // Next state.
    always_comb begin
        phase_next     = phase_reg;
        held_next      = held_reg;
        remaining_next = remaining_reg;
        length_next    = length_reg;
        cp_next        = cp_reg;
        hex_next       = hex_reg;
        hex_cnt_next   = hex_cnt_reg;
        hex_bad_next   = hex_bad_reg;
        high_next      = high_reg;
        if (step_valid) begin
            case (phase_reg)
                PH_ESC: begin
                    phase_next = PH_BODY;
                    if (!step_eot && step_byte == 8'h75) begin
                        phase_next   = PH_HEX_FIRST;
                        hex_next     = '0;
                        hex_cnt_next = '0;
                        hex_bad_next = 1'b0;
                    end
                end
                PH_UTF8: begin
                    if (step_eot || !is_cont) begin
                        phase_next = PH_BODY;
                    end else begin
                        cp_next        = cp_cont;
                        remaining_next = remaining_dec;
                        if (remaining_reg > 2'd1 && held_pos < 3'd3) begin
                            held_next[held_pos[1:0]] = step_byte;
                        end
                        if (remaining_dec == 2'd0) begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_HEX_FIRST, PH_HEX_LOW: begin
                    if (step_eot) begin
                        phase_next = PH_BODY;
                    end else begin
                        hex_next     = hex_new;
                        hex_cnt_next = hex_cnt_new;
                        hex_bad_next = hex_bad_any;
                        if (hex_done) begin
                            phase_next = PH_BODY;
                            if (phase_reg == PH_HEX_FIRST && !hex_bad_any &&
                                hex_is_high) begin
                                high_next  = hex_new[9:0];
                                phase_next = PH_PAIR_BSL;
                            end
                        end
                    end
                end
                PH_PAIR_BSL: begin
                    if (step_eot || step_byte != 8'h5C) begin
                        phase_next = PH_BODY;
                    end else begin
                        phase_next = PH_PAIR_U;
                    end
                end
                PH_PAIR_U: begin
                    if (step_eot || step_byte != 8'h75) begin
                        phase_next = PH_BODY;
                    end else begin
                        phase_next   = PH_HEX_LOW;
                        hex_next     = '0;
                        hex_cnt_next = '0;
                        hex_bad_next = 1'b0;
                    end
                end
                default: begin
                    phase_next = PH_BODY;
                    if (!step_eot && step_byte >= 8'h80 && lead_len != 3'd0) begin
                        phase_next     = PH_UTF8;
                        length_next    = lead_len;
                        cp_next        = lead_cp;
                        held_next[0]   = step_byte;
                        remaining_next = lead_len[1:0] - 2'd1;
                    end else if (!step_eot && step_byte == 8'h5C) begin
                        phase_next = PH_ESC;
                    end
                end
            endcase
        end
    end

    // Results of the current byte.
    always_comb begin
        batch       = '0;
        batch.kind  = KIND_BYTE;
        batch.err   = ERR_NONE;
        if (step_valid) begin
            case (phase_reg)
                PH_ESC: begin
                    batch.count = 3'd1;
                    if (step_eot) begin
                        batch.kind = KIND_ERROR;
                        batch.err  = ERR_ESC_END;
                    end else begin
                        case (step_byte)
                            8'h22:   batch.bytes[0] = 8'h22;
                            8'h5C:   batch.bytes[0] = 8'h5C;
                            8'h2F:   batch.bytes[0] = 8'h2F;
                            8'h62:   batch.bytes[0] = 8'h08;
                            8'h66:   batch.bytes[0] = 8'h0C;
                            8'h6E:   batch.bytes[0] = 8'h0A;
                            8'h72:   batch.bytes[0] = 8'h0D;
                            8'h74:   batch.bytes[0] = 8'h09;
                            8'h75:   batch.count    = 3'd0;
                            default: begin
                                batch.kind = KIND_ERROR;
                                batch.err  = ERR_BAD_ESC;
                            end
                        endcase
                    end
                end
                PH_UTF8: begin
                    if (step_eot || !is_cont) begin
                        batch.count = 3'd1;
                        batch.kind  = KIND_ERROR;
                        batch.err   = ERR_BAD_UTF8;
                    end else if (remaining_dec == 2'd0) begin
                        if (utf8_bad_final) begin
                            batch.count = 3'd1;
                            batch.kind  = KIND_ERROR;
                            batch.err   = ERR_BAD_UTF8;
                        end else begin
                            // Held bytes first, the final byte closes the sequence.
                            batch.count = length_reg;
                            for (int i = 0; i < MAX_RESULTS; i++) begin
                                if (i == int'(length_reg) - 1) begin
                                    batch.bytes[i] = step_byte;
                                end else if (i < 3) begin
                                    batch.bytes[i] = held_reg[i];
                                end
                            end
                        end
                    end
                end
                PH_HEX_FIRST, PH_HEX_LOW: begin
                    if (step_eot) begin
                        batch.count = 3'd1;
                        batch.kind  = KIND_ERROR;
                        batch.err   = ERR_HEX_TRUNC;
                    end else if (hex_done) begin
                        if (hex_bad_any) begin
                            batch.count = 3'd1;
                            batch.kind  = KIND_ERROR;
                            batch.err   = ERR_BAD_HEX;
                        end else if (phase_reg == PH_HEX_FIRST && hex_is_low) begin
                            batch.count = 3'd1;
                            batch.kind  = KIND_ERROR;
                            batch.err   = ERR_LONE_LOW;
                        end else if (phase_reg == PH_HEX_LOW && !hex_is_low) begin
                            batch.count = 3'd1;
                            batch.kind  = KIND_ERROR;
                            batch.err   = ERR_LONE_HIGH;
                        end else if (phase_reg == PH_HEX_LOW || !hex_is_high) begin
                            batch.count = enc.count;
                            batch.bytes = enc.bytes;
                        end
                    end
                end
                PH_PAIR_BSL: begin
                    if (step_eot || step_byte != 8'h5C) begin
                        batch.count = 3'd1;
                        batch.kind  = KIND_ERROR;
                        batch.err   = ERR_LONE_HIGH;
                    end
                end
                PH_PAIR_U: begin
                    if (step_eot || step_byte != 8'h75) begin
                        batch.count = 3'd1;
                        batch.kind  = KIND_ERROR;
                        batch.err   = ERR_LONE_HIGH;
                    end
                end
                default: begin
                    batch.count = 3'd1;
                    if (step_eot) begin
                        batch.kind = KIND_ERROR;
                        batch.err  = ERR_UNTERMINATED;
                    end else if (step_byte == 8'h22) begin
                        batch.kind = KIND_CLOSE;
                    end else if (step_byte < 8'h20) begin
                        batch.kind = KIND_ERROR;
                        batch.err  = ERR_CONTROL;
                    end else if (step_byte >= 8'h80) begin
                        if (lead_len == 3'd0) begin
                            batch.kind = KIND_ERROR;
                            batch.err  = ERR_BAD_UTF8;
                        end else begin
                            batch.count = 3'd0;
                        end
                    end else if (step_byte == 8'h5C) begin
                        batch.count = 3'd0;
                    end else begin
                        batch.bytes[0] = step_byte;
                    end
                end
            endcase
        end
    end

    // State registers; only the phase needs a reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_BODY;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg      <= held_next;
        remaining_reg <= remaining_next;
        length_reg    <= length_next;
        cp_reg        <= cp_next;
        hex_reg       <= hex_next;
        hex_cnt_reg   <= hex_cnt_next;
        hex_bad_reg   <= hex_bad_next;
        high_reg      <= high_next;
    end

    // A sequence in progress always has continuation bytes left to take.
    property p_utf8_pending;
        @(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_UTF8) |-> (remaining_reg != 2'd0);
    endproperty
    a_utf8_pending: assert property (p_utf8_pending)
        else $error("UTF-8 phase with no continuation bytes pending");

    // A close or an error is the only result of its byte.
    property p_single_terminal;
        @(posedge aclk) disable iff (!aresetn)
        (step_valid && batch.kind != KIND_BYTE) |-> (batch.count == 3'd1);
    endproperty
    a_single_terminal: assert property (p_single_terminal)
        else $error("Close or error result grouped with other results");

    // A close or an error returns the decoder to the body phase.
    property p_terminal_to_body;
        @(posedge aclk) disable iff (!aresetn)
        (step_valid && batch.kind != KIND_BYTE) |=> (phase_reg == PH_BODY);
    endproperty
    a_terminal_to_body: assert property (p_terminal_to_body)
        else $error("Decoder did not return to the body phase");

endmodule
`default_nettype wire

// File: design/jsu_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape result stage
// Result register: holds the group of results of one byte and hands them
// out one transaction per cycle while m_ready is high, marking the last of the group.
// ----------------------------------------------------------------------------
module jsu_emit
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire batch_t     push_batch,
    output logic            push_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_result_kind,
    output logic [7:0]      m_out_byte,
    output logic [3:0]      m_error_code,
    output logic            m_last_of_run
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    batch_t     batch_reg, batch_next;
    logic       last;
    logic       pop;

    // Position within the group and the output transaction.
    always_comb begin
        last          = (({1'b0, idx_reg} + 3'd1) == batch_reg.count);
        pop           = valid_reg && m_ready;
        push_ready    = !valid_reg || (m_ready && last);
        m_valid       = valid_reg;
        m_result_kind = batch_reg.kind;
        m_out_byte    = batch_reg.bytes[idx_reg];
        m_error_code  = batch_reg.err;
        m_last_of_run = last;
    end

    // Load a new group once the current one has gone; empty groups are dropped.
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        batch_next = batch_reg;
        if (push && push_ready) begin
            valid_next = (push_batch.count != 3'd0);
            idx_next   = '0;
            batch_next = push_batch;
        end else if (pop) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        batch_reg <= batch_next;
    end

    // Closes and errors always end their run.
    property p_terminal_last;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != KIND_BYTE) |-> m_last_of_run;
    endproperty
    a_terminal_last: assert property (p_terminal_last)
        else $error("Close or error result not marked last");

    // Error codes appear with error results only.
    property p_error_code;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_result_kind == KIND_ERROR) == (m_error_code != ERR_NONE));
    endproperty
    a_error_code: assert property (p_error_code)
        else $error("Error code does not match the result kind");

    // Within a group the position never passes the count.
    property p_idx_in_range;
        @(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ({1'b0, idx_reg} < batch_reg.count);
    endproperty
    a_idx_in_range: assert property (p_idx_in_range)
        else $error("Result position beyond the group");

endmodule
`default_nettype wire

// File: design/json_string_unescape_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Decodes the bytes of a JSON string body into UTF-8 bytes, with escape,
// surrogate-pair and raw UTF-8 checking, and reports the close or an error.
//
//   Channel  Ports  Payload                                        Flow
//   input    s_*    in_byte, end_of_text                           valid/ready
//   result   m_*    result_kind, out_byte, error_code, last_of_run valid/ready
//
// A byte is decoded from the input register once the result stage can take
// it, and its results are then held in the result register.
// One byte is taken per cycle while each byte causes at most one result and
// m_ready is high; a byte causing several results holds the input until the
// last of them leaves the result register. Synchronous active-low reset
// returns the decoder to the string body phase. A stall on the result side
// fills the result and input registers, then drops s_ready.
// ----------------------------------------------------------------------------
module json_string_unescape_decoder_core
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_end_of_text,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_result_kind,
    output logic [7:0]      m_out_byte,
    output logic [3:0]      m_error_code,
    output logic            m_last_of_run
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_eot_reg, in_eot_next;
    logic       emit_ready;
    logic       advance;
    batch_t     batch;

    // Input register: refilled whenever its byte moves on to the result stage.
    always_comb begin
        advance       = in_valid_reg && emit_ready;
        s_ready       = !in_valid_reg || emit_ready;
        in_valid_next = in_valid_reg && !advance;
        in_byte_next  = in_byte_reg;
        in_eot_next   = in_eot_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_in_byte;
            in_eot_next   = s_end_of_text;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_eot_reg  <= in_eot_next;
    end

    // Decoder state and per-byte result logic.
    jsu_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (advance),
        .step_byte  (in_byte_reg),
        .step_eot   (in_eot_reg),
        .batch      (batch)
    );

    // Result register and serialiser.
    jsu_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (advance),
        .push_batch    (batch),
        .push_ready    (emit_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_out_byte    (m_out_byte),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

    // A held input byte stays put while the result stage is busy.
    property p_input_held;
        @(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !emit_ready) |=>
            (in_valid_reg && $stable(in_byte_reg) && $stable(in_eot_reg));
    endproperty
    a_input_held: assert property (p_input_held)
        else $error("Input register changed while stalled");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescape decoder testbench
// Drives byte streams of JSON string bodies into the decoder. The strings
// hold plain characters, escapes, \u escapes, surrogate pairs and raw UTF-8,
// now and then a noise byte. Half end in a close, the rest in a fault or noise.
// A scoreboard class keeps its own copy of the decoder state. From each
// accepted byte it predicts the result transactions, and it checks every
// result against the oldest prediction. Both sides idle in random bursts.
// Once the receiver holds off for a long stretch, and the sender pauses
// until all results have been drained.
// ----------------------------------------------------------------------------
module tb_top;
    import jsu_pkg::*;

    // Character codes used by the decoder and by the stimulus.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam int RANDOM_ITEMS   = 470;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_FAULTS     = 16;

    // One result transaction as the decoder should present it.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] err;
        logic       last;
    } decoded_t;

    // Scoreboard: predicts the results of each accepted byte and checks the
    // result transactions against them in order.
    class unescape_scoreboard;
        decoded_t   expected_results[$];
        decoded_t   run[$];
        int         mismatches;
        int         checked;

        // Decoder state.
        phase_t     dec_phase;
        logic [7:0] seq_bytes[3];
        logic [1:0] seq_left;
        logic [2:0] seq_len;
        logic [20:0] seq_value;
        logic [15:0] esc_value;
        logic [2:0] esc_digits;
        logic       esc_bad;
        logic [9:0] high_half;

        function new();
            mismatches = 0;
            checked    = 0;
            restart();
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void start_digits();
            esc_value  = 16'h0;
            esc_digits = 3'd0;
            esc_bad    = 1'b0;
        endfunction

        function void restart();
            dec_phase    = PH_BODY;
            seq_bytes[0] = 8'h0;
            seq_bytes[1] = 8'h0;
            seq_bytes[2] = 8'h0;
            seq_left     = 2'd0;
            seq_len      = 3'd0;
            seq_value    = 21'h0;
            high_half    = 10'h0;
            start_digits();
        endfunction

        function void emit(kind_t k, logic [7:0] d, logic [3:0] e);
            decoded_t r;
            r.kind = k;
            r.data = d;
            r.err  = e;
            r.last = 1'b0;
            run.insert(run.size(), r);
        endfunction

        function void fail(logic [3:0] code);
            restart();
            emit(KIND_ERROR, 8'h0, code);
        endfunction

        // UTF-8 encoding of a code point, one to four bytes.
        function void emit_code_point(logic [20:0] c);
            if (c < 21'h80) begin
                emit(KIND_BYTE, c[7:0], ERR_NONE);
            end else if (c < 21'h800) begin
                emit(KIND_BYTE, {3'b110, c[10:6]}, ERR_NONE);
                emit(KIND_BYTE, {2'b10, c[5:0]}, ERR_NONE);
            end else if (c < 21'h10000) begin
                emit(KIND_BYTE, {4'b1110, c[15:12]}, ERR_NONE);
                emit(KIND_BYTE, {2'b10, c[11:6]}, ERR_NONE);
                emit(KIND_BYTE, {2'b10, c[5:0]}, ERR_NONE);
            end else begin
                emit(KIND_BYTE, {5'b11110, c[20:18]}, ERR_NONE);
                emit(KIND_BYTE, {2'b10, c[17:12]}, ERR_NONE);
                emit(KIND_BYTE, {2'b10, c[11:6]}, ERR_NONE);
                emit(KIND_BYTE, {2'b10, c[5:0]}, ERR_NONE);
            end
        endfunction

        // Takes any byte as a hex digit; true once the fourth is in.
        function bit take_digit(logic [7:0] b);
            logic [3:0] d;
            d = 4'h0;
            if (b >= CH_0 && b <= CH_9) d = 4'(b - CH_0);
            else if (b >= CH_LA && b <= CH_LF) d = 4'(b - CH_LA + 8'd10);
            else if (b >= CH_UA && b <= CH_UF) d = 4'(b - CH_UA + 8'd10);
            else esc_bad = 1'b1;
            esc_value  = {esc_value[11:0], d};
            esc_digits = esc_digits + 3'd1;
            return esc_digits >= 3'd4;
        endfunction

        function void decode_escape(logic [7:0] b, logic eot);
            if (eot) begin
                fail(ERR_ESC_END);
            end else begin
                dec_phase = PH_BODY;
                case (b)
                    CH_QUOTE: emit(KIND_BYTE, CH_QUOTE, ERR_NONE);
                    CH_BSL:   emit(KIND_BYTE, CH_BSL, ERR_NONE);
                    CH_SLASH: emit(KIND_BYTE, CH_SLASH, ERR_NONE);
                    CH_B:     emit(KIND_BYTE, 8'h08, ERR_NONE);
                    CH_F:     emit(KIND_BYTE, 8'h0C, ERR_NONE);
                    CH_N:     emit(KIND_BYTE, 8'h0A, ERR_NONE);
                    CH_R:     emit(KIND_BYTE, 8'h0D, ERR_NONE);
                    CH_T:     emit(KIND_BYTE, 8'h09, ERR_NONE);
                    CH_U: begin
                        start_digits();
                        dec_phase = PH_HEX_FIRST;
                    end
                    default:  fail(ERR_BAD_ESC);
                endcase
            end
        endfunction

        function void decode_utf8(logic [7:0] b, logic eot);
            logic [2:0]  idx;
            logic [20:0] minimum;
            int          i;
            if (eot || b[7:6] != 2'b10) begin
                fail(ERR_BAD_UTF8);
            end else begin
                seq_value = {seq_value[14:0], b[5:0]};
                if (seq_left > 2'd1) begin
                    idx = seq_len - 3'(seq_left);
                    if (idx < 3'd3) seq_bytes[idx] = b;
                end
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0) begin
                    minimum = (seq_len == 3'd2) ? 21'h80 :
                              (seq_len == 3'd3) ? 21'h800 : 21'h10000;
                    if (seq_value < minimum || seq_value > 21'h10FFFF ||
                        (seq_value >= 21'hD800 && seq_value <= 21'hDFFF)) begin
                        fail(ERR_BAD_UTF8);
                    end else begin
                        for (i = 0; i + 1 < int'(seq_len) && i < 3; i++)
                            emit(KIND_BYTE, seq_bytes[i], ERR_NONE);
                        emit(KIND_BYTE, b, ERR_NONE);
                        dec_phase = PH_BODY;
                    end
                end
            end
        endfunction

        function void decode_body(logic [7:0] b, logic eot);
            bit lead_ok;
            lead_ok = 1'b1;
            if (eot) begin
                fail(ERR_UNTERMINATED);
            end else if (b == CH_QUOTE) begin
                restart();
                emit(KIND_CLOSE, 8'h0, ERR_NONE);
            end else if (b < 8'h20) begin
                fail(ERR_CONTROL);
            end else if (b >= 8'h80) begin
                if (b >= 8'hC2 && b <= 8'hDF) begin
                    seq_len   = 3'd2;
                    seq_value = {16'h0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    seq_len   = 3'd3;
                    seq_value = {17'h0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    seq_len   = 3'd4;
                    seq_value = {18'h0, b[2:0]};
                end else begin
                    lead_ok = 1'b0;
                    fail(ERR_BAD_UTF8);
                end
                if (lead_ok) begin
                    seq_bytes[0] = b;
                    seq_left     = 2'(seq_len - 3'd1);
                    dec_phase    = PH_UTF8;
                end
            end else if (b == CH_BSL) begin
                dec_phase = PH_ESC;
            end else begin
                emit(KIND_BYTE, b, ERR_NONE);
            end
        endfunction

        // Notes one accepted input transaction and queues its results.
        function void note_byte(logic [7:0] b, logic eot);
            run.delete();
            case (dec_phase)
                PH_ESC:  decode_escape(b, eot);
                PH_UTF8: decode_utf8(b, eot);
                PH_HEX_FIRST: begin
                    if (eot) begin
                        fail(ERR_HEX_TRUNC);
                    end else if (take_digit(b)) begin
                        if (esc_bad) begin
                            fail(ERR_BAD_HEX);
                        end else if (esc_value >= 16'hDC00 && esc_value <= 16'hDFFF) begin
                            fail(ERR_LONE_LOW);
                        end else if (esc_value >= 16'hD800 && esc_value <= 16'hDBFF) begin
                            high_half = 10'(esc_value - 16'hD800);
                            dec_phase = PH_PAIR_BSL;
                        end else begin
                            emit_code_point({5'h0, esc_value});
                            dec_phase = PH_BODY;
                        end
                    end
                end
                PH_PAIR_BSL: begin
                    if (eot || b != CH_BSL) fail(ERR_LONE_HIGH);
                    else dec_phase = PH_PAIR_U;
                end
                PH_PAIR_U: begin
                    if (eot || b != CH_U) begin
                        fail(ERR_LONE_HIGH);
                    end else begin
                        start_digits();
                        dec_phase = PH_HEX_LOW;
                    end
                end
                PH_HEX_LOW: begin
                    if (eot) begin
                        fail(ERR_HEX_TRUNC);
                    end else if (take_digit(b)) begin
                        if (esc_bad) begin
                            fail(ERR_BAD_HEX);
                        end else if (esc_value < 16'hDC00 || esc_value > 16'hDFFF) begin
                            fail(ERR_LONE_HIGH);
                        end else begin
                            emit_code_point(21'h10000 + {1'b0, high_half, 10'h0} +
                                            21'(esc_value - 16'hDC00));
                            dec_phase = PH_BODY;
                        end
                    end
                end
                default: decode_body(b, eot);
            endcase
            if (run.size() > 0) begin
                run[run.size() - 1].last = 1'b1;
                foreach (run[i]) expected_results.insert(expected_results.size(), run[i]);
            end
        endfunction

        // Checks one result transaction against the oldest prediction.
        function void check_result(logic [1:0] kind, logic [7:0] data,
                                   logic [3:0] err, logic last);
            decoded_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result %0d: kind %0d byte %02h code %0d last %0d",
                             checked, kind, data, err, last);
            end else begin
                want = expected_results.pop_front();
                if (kind !== want.kind || data !== want.data ||
                    err !== want.err || last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"ERROR: result %0d: expected kind %0d byte %02h code %0d ",
                                  "last %0d, got kind %0d byte %02h code %0d last %0d"},
                                 checked, want.kind, want.data, want.err, want.last,
                                 kind, data, err, last);
                end
            end
            checked++;
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_end_of_text;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_result_kind;
    logic [7:0] m_out_byte;
    logic [3:0] m_error_code;
    logic       m_last_of_run;

    unescape_scoreboard sb;
    int  sent_count  = 0;
    int  fault_sel   = 0;
    bit  tx_calm     = 1'b0;
    bit  idle_off    = 1'b0;
    bit  rx_hold_req = 1'b0;

    json_string_unescape_decoder_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_out_byte    (m_out_byte),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Result monitor: every accepted result transaction is checked.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result_kind, m_out_byte, m_error_code, m_last_of_run);
    end

    // Result sink: random stall bursts, calm stretches and one long hold-off.
    initial begin : result_sink
        int n;
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (!idle_off && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                if (!idle_off && $urandom_range(0, 5) == 0) n = $urandom_range(30, 80);
                else n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Run limit.
    initial begin : watchdog
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10) return CH_0 + 8'(n);
        return (upper ? CH_UA : CH_LA) + 8'(n) - 8'd10;
    endfunction

    function automatic bit is_hex(logic [7:0] b);
        return (b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LF) ||
               (b >= CH_UA && b <= CH_UF);
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        b = 8'($urandom);
        while (is_hex(b)) b = 8'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] escape_letter(int n);
        case (n)
            0: return CH_QUOTE;
            1: return CH_BSL;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic bit is_escape_letter(logic [7:0] b);
        return b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_B ||
               b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U;
    endfunction

    function automatic int lead_length(logic [7:0] lead);
        if (lead <= 8'hDF) return 2;
        if (lead <= 8'hEF) return 3;
        return 4;
    endfunction

    // Offers one byte, with an occasional idle burst before it, and waits
    // for the transaction.
    task automatic send_item(input logic [7:0] b, input logic eot);
        if (!idle_off && !tx_calm && $urandom_range(0, 4) == 0) begin
            s_valid       <= 1'b0;
            s_in_byte     <= 8'($urandom);
            s_end_of_text <= 1'($urandom);
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= b;
        s_end_of_text <= eot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b, eot);
        sent_count++;
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_hex4(input logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            send_item(hex_char(v[i*4 +: 4], 1'($urandom)), 1'b0);
    endtask

    task automatic send_unicode_escape(input logic [15:0] v);
        send_item(CH_BSL, 1'b0);
        send_item(CH_U, 1'b0);
        send_hex4(v);
    endtask

    // A raw sequence: lead byte, second byte from a range, then continuations.
    task automatic send_utf8(input logic [7:0] lead, input logic [7:0] lo,
                             input logic [7:0] hi, input int len);
        send_item(lead, 1'b0);
        send_item(8'($urandom_range(lo, hi)), 1'b0);
        repeat (len - 2) send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
    endtask

    // Lead byte and some continuations of a sequence that is cut short.
    task automatic send_utf8_start();
        logic [7:0] lead;
        lead = 8'($urandom_range(8'hC2, 8'hF4));
        send_item(lead, 1'b0);
        repeat ($urandom_range(0, lead_length(lead) - 2))
            send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
    endtask

    // Digits of a \u escape that are cut off by the end of text or hold a
    // non-hex byte.
    task automatic send_broken_digits(input bit truncate);
        int bad_at;
        if (truncate) begin
            repeat ($urandom_range(0, 3)) send_item(8'($urandom), 1'b0);
            send_item(8'($urandom), 1'b1);
        end else begin
            bad_at = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++)
                send_item(i == bad_at ? non_hex() : hex_char(4'($urandom), 1'($urandom)),
                          1'b0);
        end
    endtask

    task automatic send_valid_utf8();
        logic [7:0] lead;
        case ($urandom_range(0, 2))
            0: send_utf8(8'($urandom_range(8'hC2, 8'hDF)), 8'h80, 8'hBF, 2);
            1: begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                send_utf8(lead, lead == 8'hE0 ? 8'hA0 : 8'h80,
                          lead == 8'hED ? 8'h9F : 8'hBF, 3);
            end
            default: begin
                lead = 8'($urandom_range(8'hF0, 8'hF4));
                send_utf8(lead, lead == 8'hF0 ? 8'h90 : 8'h80,
                          lead == 8'hF4 ? 8'h8F : 8'hBF, 4);
            end
        endcase
    endtask

    task automatic send_bmp_escape();
        case ($urandom_range(0, 3))
            0: send_unicode_escape(16'($urandom_range(16'h0000, 16'h007F)));
            1: send_unicode_escape(16'($urandom_range(16'h0080, 16'h07FF)));
            2: send_unicode_escape(16'($urandom_range(16'h0800, 16'hD7FF)));
            default: send_unicode_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
        endcase
    endtask

    // One well-formed piece of a string body, or now and then a noise byte.
    task automatic send_token();
        logic [7:0] b;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            b = 8'($urandom_range(8'h20, 8'h7F));
            if (b == CH_QUOTE || b == CH_BSL) b = CH_UA;
            send_item(b, 1'b0);
        end else if (pick < 55) begin
            send_item(CH_BSL, 1'b0);
            send_item(escape_letter($urandom_range(0, 7)), 1'b0);
        end else if (pick < 67) begin
            send_bmp_escape();
        end else if (pick < 75) begin
            send_unicode_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            send_unicode_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else if (pick < 92) begin
            send_valid_utf8();
        end else begin
            send_item(8'($urandom), $urandom_range(0, 15) == 0);
        end
    endtask

    // A broken ending; the kinds are taken in turn so that each one occurs.
    task automatic send_fault();
        logic [7:0]  b;
        logic [15:0] v;
        fault_sel = (fault_sel + 1) % NUM_FAULTS;
        case (fault_sel)
            0: send_item(8'($urandom), 1'b1);
            1: send_item(8'($urandom_range(8'h00, 8'h1F)), 1'b0);
            2: begin
                if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(8'h80, 8'hC1));
                else b = 8'($urandom_range(8'hF5, 8'hFF));
                send_item(b, 1'b0);
            end
            3: begin
                send_utf8_start();
                b = 8'($urandom);
                if (b[7:6] == 2'b10) b[6] = 1'b1;
                if ($urandom_range(0, 7) == 0) b = CH_QUOTE;
                send_item(b, 1'b0);
            end
            4: begin
                send_utf8_start();
                send_item(8'($urandom), 1'b1);
            end
            5: begin
                if ($urandom_range(0, 1) == 0) send_utf8(8'hE0, 8'h80, 8'h9F, 3);
                else send_utf8(8'hF0, 8'h80, 8'h8F, 4);
            end
            6: send_utf8(8'hED, 8'hA0, 8'hBF, 3);
            7: send_utf8(8'hF4, 8'h90, 8'hBF, 4);
            8: begin
                send_item(CH_BSL, 1'b0);
                send_item(8'($urandom), 1'b1);
            end
            9: begin
                b = 8'($urandom);
                while (is_escape_letter(b)) b = 8'($urandom);
                send_item(CH_BSL, 1'b0);
                send_item(b, 1'b0);
            end
            10, 11: begin
                send_item(CH_BSL, 1'b0);
                send_item(CH_U, 1'b0);
                send_broken_digits(fault_sel == 10);
            end
            12: send_unicode_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            13: begin
                send_unicode_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                case ($urandom_range(0, 3))
                    0: begin
                        b = 8'($urandom);
                        if (b == CH_BSL) b = CH_QUOTE;
                        send_item(b, 1'b0);
                    end
                    1: begin
                        send_item(CH_BSL, 1'b0);
                        b = 8'($urandom);
                        if (b == CH_U) b = CH_N;
                        send_item(b, $urandom_range(0, 3) == 0);
                    end
                    2: send_item(8'($urandom), 1'b1);
                    default: begin
                        v = 16'($urandom);
                        if (v[15:10] == 6'b110111) v[13] = 1'b0;
                        send_unicode_escape(v);
                    end
                endcase
            end
            14: begin
                send_unicode_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                send_item(CH_BSL, 1'b0);
                send_item(CH_U, 1'b0);
                send_broken_digits(1'($urandom));
            end
            default: begin
                // Four arbitrary bytes taken as digits.
                send_item(CH_BSL, 1'b0);
                send_item(CH_U, 1'b0);
                repeat (4) send_item(8'($urandom), 1'b0);
            end
        endcase
    endtask

    // One string body: a few pieces, then a close, a fault or noise.
    task automatic send_string();
        tx_calm = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 6)) send_token();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_fault();
            4: repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'($urandom));
            default: send_item(CH_QUOTE, 1'b0);
        endcase
    endtask

    // Main sequence.
    initial begin : stimulus
        int  random_start;
        bit  hold_done;
        bit  pause_done;
        sb            = new();
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_in_byte     <= 8'h00;
        s_end_of_text <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: field extremes, a four-byte raw sequence, the
        // smallest two-byte sequence, a surrogate pair, close and errors.
        send_item(8'h20, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(CH_BSL, 1'b0);
        send_item(CH_N, 1'b0);
        send_item(8'hF4, 1'b0);
        send_item(8'h8F, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hC2, 1'b0);
        send_item(8'h80, 1'b0);
        send_unicode_escape(16'hD800);
        send_unicode_escape(16'hDC00);
        send_item(CH_QUOTE, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        wait_drained();

        // Random strings.
        random_start = sent_count;
        while (sent_count - random_start < RANDOM_ITEMS) begin
            if (!hold_done && sent_count - random_start >= 60) begin
                rx_hold_req = 1'b1;
                hold_done   = 1'b1;
            end
            if (!pause_done && sent_count - random_start >= RANDOM_ITEMS / 2) begin
                wait_drained();
                pause_done = 1'b1;
            end
            if (sent_count - random_start >= RANDOM_ITEMS * 85 / 100) idle_off = 1'b1;
            send_string();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
design/jsu_pkg.sv
design/jsu_step.sv
design/jsu_emit.sv
design/json_string_unescape_decoder_core.sv
dv/tb_top.sv
